### rtl/obcce_pkg.sv
// Shared types and constants for the one-button click counter editor.
package obcce_pkg;

    localparam int CFG_W     = 16;
    localparam int DISPLAY_W = 12;
    localparam int INDEX_W   = 2;

    localparam logic [INDEX_W-1:0] REG_WINDOW    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [INDEX_W-1:0] REG_INTERVAL  = 2'd2;

    localparam logic [CFG_W-1:0] WINDOW_RESET    = 16'd300;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd500;
    localparam logic [CFG_W-1:0] INTERVAL_RESET  = 16'd400;

    localparam int COUNT_RESET = 2;

    typedef enum logic [1:0] {
        MODE_BASE = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DOWN = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRESSED = 3'd1,
        PH_WAIT    = 3'd2,
        PH_SECOND  = 3'd3,
        PH_HOLDING = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_HOLD   = 2'd3
    } event_t;

    typedef struct packed {
        event_t ev;
        logic   step;
        logic   hold_end;
    } gest_t;

endpackage

### rtl/one_button_click_counter_editor_unit.sv
// Top level of the one-button click counter editor.
//
//  channel | signals                                    | direction
//  in      | in_valid, in_stall, button_pressed         | word in
//  out     | out_valid, out_stall, count_value, mode,   | word out
//          | click_event                                |
//  cfg     | cfg_write, cfg_index, cfg_data             | register write
//
// A word accepted into the input register is run through the gesture and editor logic
// into state when it advances, and its result is then valid; a stalled output holds it back.
// A new word is accepted every cycle while the result side keeps up.
// The editor state registers hold the result word, so a stalled result holds.
// Reset clears the pipeline, the gesture phase and timer, the mode and sets
// the counter to two; configuration registers return to their defaults.
module one_button_click_counter_editor_unit #(
    parameter int COUNT_WIDTH = 12,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                button_pressed,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [obcce_pkg::DISPLAY_W-1:0]     count_value,
    output logic [1:0]                          mode,
    output logic [1:0]                          click_event,
    input  logic                                cfg_write,
    input  logic [obcce_pkg::INDEX_W-1:0]       cfg_index,
    input  logic [obcce_pkg::CFG_W-1:0]         cfg_data
);

    logic                          s1_valid_reg;
    logic                          s1_press_reg;
    logic                          out_valid_reg;
    obcce_pkg::event_t             ev_reg;
    logic                          advance;
    logic [obcce_pkg::CFG_W-1:0]   window_reg;
    logic [obcce_pkg::CFG_W-1:0]   threshold_reg;
    logic [obcce_pkg::CFG_W-1:0]   interval_reg;
    obcce_pkg::gest_t              gest;
    logic                          mode_active;
    obcce_pkg::mode_t              mode_reg;
    logic [COUNT_WIDTH-1:0]        count_reg;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_press_reg <= button_pressed;
        if (advance)
            ev_reg <= gest.ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= obcce_pkg::WINDOW_RESET;
            threshold_reg <= obcce_pkg::THRESHOLD_RESET;
            interval_reg  <= obcce_pkg::INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                obcce_pkg::REG_WINDOW:    window_reg    <= cfg_data;
                obcce_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                obcce_pkg::REG_INTERVAL:  interval_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    obcce_gesture #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_gesture (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .pressed     (s1_press_reg),
        .mode_active (mode_active),
        .window      (window_reg),
        .threshold   (threshold_reg),
        .interval    (interval_reg),
        .gest        (gest)
    );

    obcce_editor #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_editor (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .gest        (gest),
        .mode_active (mode_active),
        .mode_reg    (mode_reg),
        .count_reg   (count_reg)
    );

    generate
        if (COUNT_WIDTH >= obcce_pkg::DISPLAY_W)
        begin : g_count_wide
            assign count_value = count_reg[obcce_pkg::DISPLAY_W-1:0];
        end
        else
        begin : g_count_narrow
            assign count_value = {{(obcce_pkg::DISPLAY_W-COUNT_WIDTH){1'b0}}, count_reg};
        end
    endgenerate

    assign out_valid   = out_valid_reg;
    assign mode        = mode_reg;
    assign click_event = ev_reg;

endmodule

### rtl/obcce_gesture.sv
// Gesture classifier: click phase and saturating tick timer.
module obcce_gesture #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          pressed,
    input  logic                          mode_active,
    input  logic [obcce_pkg::CFG_W-1:0]   window,
    input  logic [obcce_pkg::CFG_W-1:0]   threshold,
    input  logic [obcce_pkg::CFG_W-1:0]   interval,
    output obcce_pkg::gest_t              gest
);

    localparam int CW = (TIMER_WIDTH > obcce_pkg::CFG_W) ? TIMER_WIDTH : obcce_pkg::CFG_W;

    obcce_pkg::phase_t         phase_reg;
    obcce_pkg::phase_t         phase_next;
    logic [TIMER_WIDTH-1:0]    timer_reg;
    logic [TIMER_WIDTH-1:0]    timer_next;
    logic [TIMER_WIDTH-1:0]    timer_inc;
    logic [CW-1:0]             inc_x;

    assign timer_inc = (&timer_reg) ? timer_reg : timer_reg + TIMER_WIDTH'(1);
    assign inc_x     = CW'(timer_inc);

    always_comb
    begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        gest.ev       = obcce_pkg::EV_NONE;
        gest.step     = 1'b0;
        gest.hold_end = 1'b0;
        unique case (phase_reg)
            obcce_pkg::PH_PRESSED:
            begin
                if (pressed)
                begin
                    timer_next = timer_inc;
                    if (inc_x > CW'(threshold))
                    begin
                        gest.ev    = obcce_pkg::EV_HOLD;
                        phase_next = obcce_pkg::PH_HOLDING;
                        timer_next = '1;
                    end
                end
                else
                begin
                    timer_next = '0;
                    phase_next = obcce_pkg::PH_WAIT;
                end
            end
            obcce_pkg::PH_WAIT:
            begin
                timer_next = timer_inc;
                if (inc_x > CW'(window))
                begin
                    gest.ev    = obcce_pkg::EV_SINGLE;
                    phase_next = obcce_pkg::PH_IDLE;
                end
                else if (pressed)
                begin
                    phase_next = obcce_pkg::PH_SECOND;
                end
            end
            obcce_pkg::PH_SECOND:
            begin
                if (!pressed)
                begin
                    gest.ev    = obcce_pkg::EV_DOUBLE;
                    phase_next = obcce_pkg::PH_IDLE;
                end
            end
            obcce_pkg::PH_HOLDING:
            begin
                if (!pressed)
                begin
                    phase_next    = obcce_pkg::PH_IDLE;
                    gest.hold_end = 1'b1;
                end
                else if (mode_active)
                begin
                    timer_next = timer_inc;
                    if (inc_x >= CW'(interval))
                    begin
                        gest.step  = 1'b1;
                        timer_next = '0;
                    end
                end
            end
            default:
            begin
                phase_next = obcce_pkg::PH_IDLE;
                if (pressed)
                begin
                    timer_next = '0;
                    phase_next = obcce_pkg::PH_PRESSED;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= obcce_pkg::PH_IDLE;
            timer_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
        end
    end

`ifndef SYNTHESIS
    a_hold_enters_holding: assert property (@(posedge clk) disable iff (!rst_n)
        advance && gest.ev == obcce_pkg::EV_HOLD |=>
            phase_reg == obcce_pkg::PH_HOLDING && (&timer_reg))
        else $error("Hold did not enter the holding phase with a saturated timer.");
`endif

endmodule

### rtl/obcce_editor.sv
// Editor mode machine and wrapping counter.
module obcce_editor #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  obcce_pkg::gest_t        gest,
    output logic                    mode_active,
    output obcce_pkg::mode_t        mode_reg,
    output logic [COUNT_WIDTH-1:0]  count_reg
);

    obcce_pkg::mode_t          mode_next;
    logic [COUNT_WIDTH-1:0]    count_next;
    logic                      do_step;

    assign mode_active = (mode_reg == obcce_pkg::MODE_UP) ||
                         (mode_reg == obcce_pkg::MODE_DOWN);

    assign do_step = gest.step || (gest.ev == obcce_pkg::EV_SINGLE && mode_active);

    always_comb
    begin
        count_next = count_reg;
        if (do_step)
        begin
            if (mode_reg == obcce_pkg::MODE_DOWN)
                count_next = count_reg - COUNT_WIDTH'(1);
            else if (mode_reg == obcce_pkg::MODE_UP)
                count_next = count_reg + COUNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        unique case (gest.ev)
            obcce_pkg::EV_SINGLE:
            begin
                if (!mode_active)
                    mode_next = obcce_pkg::MODE_UP;
            end
            obcce_pkg::EV_DOUBLE:
            begin
                mode_next = mode_active ? obcce_pkg::MODE_BASE : obcce_pkg::MODE_DOWN;
            end
            default:
            begin
                if (gest.hold_end && !mode_active)
                    mode_next = obcce_pkg::MODE_UP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= obcce_pkg::MODE_BASE;
            count_reg <= COUNT_WIDTH'(obcce_pkg::COUNT_RESET);
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_single_up_steps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && gest.ev == obcce_pkg::EV_SINGLE && mode_reg == obcce_pkg::MODE_UP |=>
            count_reg == $past(count_reg) + COUNT_WIDTH'(1))
        else $error("Single click in up mode did not step the counter.");

    a_double_to_base: assert property (@(posedge clk) disable iff (!rst_n)
        advance && gest.ev == obcce_pkg::EV_DOUBLE && mode_active |=>
            mode_reg == obcce_pkg::MODE_BASE)
        else $error("Double click in up or down mode did not return to base.");

    a_hold_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(count_reg) && $stable(mode_reg))
        else $error("Editor state changed without an advancing word.");
`endif

endmodule

### tb/sv/click_editor_monitor.sv
// Watches the editor channels, predicts every result word and compares it with the block.
`timescale 1ns / 1ps

module click_editor_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            button_pressed,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [obcce_pkg::DISPLAY_W-1:0] count_value,
    input  logic [1:0]                      mode,
    input  logic [1:0]                      click_event,
    input  logic                            cfg_write,
    input  logic [obcce_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [obcce_pkg::CFG_W-1:0]     cfg_data,
    output int                              fail_count,
    output int                              pending_words
);

    localparam int TIMER_W = 16;

    typedef struct packed {
        logic [obcce_pkg::DISPLAY_W-1:0] count;
        obcce_pkg::mode_t                md;
        obcce_pkg::event_t               ev;
    } display_t;

    logic [obcce_pkg::CFG_W-1:0]     window_ms;
    logic [obcce_pkg::CFG_W-1:0]     threshold_ms;
    logic [obcce_pkg::CFG_W-1:0]     interval_ms;
    obcce_pkg::mode_t                editor_md;
    obcce_pkg::phase_t               gesture_phase;
    logic [TIMER_W-1:0]              tick_count;
    logic [obcce_pkg::DISPLAY_W-1:0] edit_count;
    display_t                        display_q[$];

    task automatic bump_ticks();
        if (tick_count != '1)
            tick_count = tick_count + 1'b1;
    endtask

    task automatic step_edit_count();
        if (editor_md == obcce_pkg::MODE_DOWN)
            edit_count = edit_count - 1'b1;
        else if (editor_md == obcce_pkg::MODE_UP)
            edit_count = edit_count + 1'b1;
    endtask

    task automatic advance_editor(input logic pressed, output display_t word);
        obcce_pkg::event_t ev;
        logic              editing;
        ev      = obcce_pkg::EV_NONE;
        editing = (editor_md == obcce_pkg::MODE_UP) || (editor_md == obcce_pkg::MODE_DOWN);
        case (gesture_phase)
            obcce_pkg::PH_PRESSED:
            begin
                if (pressed)
                begin
                    bump_ticks();
                    if (tick_count > threshold_ms)
                    begin
                        ev            = obcce_pkg::EV_HOLD;
                        gesture_phase = obcce_pkg::PH_HOLDING;
                        // A saturated timer makes the next held tick in up or down mode step at once.
                        tick_count    = '1;
                    end
                end
                else
                begin
                    tick_count    = '0;
                    gesture_phase = obcce_pkg::PH_WAIT;
                end
            end
            obcce_pkg::PH_WAIT:
            begin
                bump_ticks();
                if (tick_count > window_ms)
                begin
                    ev            = obcce_pkg::EV_SINGLE;
                    gesture_phase = obcce_pkg::PH_IDLE;
                end
                else if (pressed)
                    gesture_phase = obcce_pkg::PH_SECOND;
            end
            obcce_pkg::PH_SECOND:
            begin
                if (!pressed)
                begin
                    ev            = obcce_pkg::EV_DOUBLE;
                    gesture_phase = obcce_pkg::PH_IDLE;
                end
            end
            obcce_pkg::PH_HOLDING:
            begin
                if (!pressed)
                begin
                    gesture_phase = obcce_pkg::PH_IDLE;
                    if (!editing)
                        editor_md = obcce_pkg::MODE_UP;
                end
                else if (editing)
                begin
                    bump_ticks();
                    if (tick_count >= interval_ms)
                    begin
                        step_edit_count();
                        tick_count = '0;
                    end
                end
            end
            default:
            begin
                gesture_phase = obcce_pkg::PH_IDLE;
                if (pressed)
                begin
                    tick_count    = '0;
                    gesture_phase = obcce_pkg::PH_PRESSED;
                end
            end
        endcase

        if (ev == obcce_pkg::EV_SINGLE)
        begin
            if (editing)
                step_edit_count();
            else
                editor_md = obcce_pkg::MODE_UP;
        end
        else if (ev == obcce_pkg::EV_DOUBLE)
        begin
            if (editing)
                editor_md = obcce_pkg::MODE_BASE;
            else
                editor_md = obcce_pkg::MODE_DOWN;
        end

        word.count = edit_count;
        word.md    = editor_md;
        word.ev    = ev;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        display_t want;
        display_t next_word;
        if (!rst_n)
        begin
            window_ms     = obcce_pkg::WINDOW_RESET;
            threshold_ms  = obcce_pkg::THRESHOLD_RESET;
            interval_ms   = obcce_pkg::INTERVAL_RESET;
            editor_md     = obcce_pkg::MODE_BASE;
            gesture_phase = obcce_pkg::PH_IDLE;
            tick_count    = '0;
            edit_count    = obcce_pkg::COUNT_RESET[obcce_pkg::DISPLAY_W-1:0];
            display_q.delete();
            pending_words = 0;
            fail_count    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (display_q.size() == 0)
                begin
                    $error("unexpected result word: count_value %0d mode %0d click_event %0d",
                           count_value, mode, click_event);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = display_q.pop_front();
                    if (count_value !== want.count)
                    begin
                        $error("count_value: expected %0d, got %0d", want.count, count_value);
                        fail_count = fail_count + 1;
                    end
                    if (mode !== want.md)
                    begin
                        $error("mode: expected %0d, got %0d", want.md, mode);
                        fail_count = fail_count + 1;
                    end
                    if (click_event !== want.ev)
                    begin
                        $error("click_event: expected %0d, got %0d", want.ev, click_event);
                        fail_count = fail_count + 1;
                    end
                end
            end

            if (cfg_write)
            begin
                if (cfg_index == obcce_pkg::REG_WINDOW)
                    window_ms = cfg_data;
                else if (cfg_index == obcce_pkg::REG_THRESHOLD)
                    threshold_ms = cfg_data;
                else if (cfg_index == obcce_pkg::REG_INTERVAL)
                    interval_ms = cfg_data;
            end

            if (in_valid && !in_stall)
            begin
                advance_editor(button_pressed, next_word);
                display_q.push_back(next_word);
            end
            pending_words = display_q.size();
        end
    end

endmodule

### tb/sv/one_button_click_counter_editor_unit_tb.sv
// Testbench top: drives button gestures and timing settings into the click counter editor.
`timescale 1ns / 1ps

module one_button_click_counter_editor_unit_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_WORDS = 1150;

    logic                            clk            = 1'b0;
    logic                            rst_n          = 1'b0;
    logic                            in_valid       = 1'b0;
    logic                            in_stall;
    logic                            button_pressed = 1'b0;
    logic                            out_valid;
    logic                            out_stall      = 1'b0;
    logic [obcce_pkg::DISPLAY_W-1:0] count_value;
    logic [1:0]                      mode;
    logic [1:0]                      click_event;
    logic                            cfg_write      = 1'b0;
    logic [obcce_pkg::INDEX_W-1:0]   cfg_index      = obcce_pkg::REG_WINDOW;
    logic [obcce_pkg::CFG_W-1:0]     cfg_data       = '0;

    int fail_count;
    int pending_words;
    int cycle_count = 0;
    int words_sent  = 0;
    int settings    = 0;
    int burst_left  = 0;
    int win         = int'(obcce_pkg::WINDOW_RESET);
    int thr         = int'(obcce_pkg::THRESHOLD_RESET);
    int itv         = int'(obcce_pkg::INTERVAL_RESET);

    one_button_click_counter_editor_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .count_value    (count_value),
        .mode           (mode),
        .click_event    (click_event),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    click_editor_monitor monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .count_value    (count_value),
        .mode           (mode),
        .click_event    (click_event),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_words  (pending_words)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d words outstanding",
                     cycle_count, pending_words);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // The result side stalls in segments of random density, with one long hold-off early on.
    initial
    begin : receiver
        int seg;
        int pct;
        int rx_cycles;
        bit held_off;
        rx_cycles = 0;
        held_off  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && rx_cycles > 300)
            begin
                held_off = 1'b1;
                repeat (100)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    rx_cycles++;
                end
            end
            seg = $urandom_range(10, 60);
            case ($urandom_range(0, 4))
                0, 1:    pct = 0;
                2:       pct = 20;
                3:       pct = 50;
                default: pct = 85;
            endcase
            repeat (seg)
            begin
                @(negedge clk);
                out_stall <= ($urandom_range(0, 99) < pct);
                rx_cycles++;
            end
        end
    end

    task automatic send_word(input logic level);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid       <= 1'b1;
        button_pressed <= level;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        burst_left--;
        words_sent++;
    endtask

    task automatic press_release(input int held, input int released);
        repeat (held) send_word(1'b1);
        repeat (released) send_word(1'b0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_timing(input logic [obcce_pkg::CFG_W-1:0] w,
                                  input logic [obcce_pkg::CFG_W-1:0] t,
                                  input logic [obcce_pkg::CFG_W-1:0] r);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= obcce_pkg::REG_WINDOW;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= obcce_pkg::REG_THRESHOLD;
        cfg_data  <= t;
        @(negedge clk);
        cfg_index <= obcce_pkg::REG_INTERVAL;
        cfg_data  <= r;
        @(negedge clk);
        cfg_write <= 1'b0;
        win = int'(w);
        thr = int'(t);
        itv = int'(r);
        settings++;
    endtask

    function automatic logic [obcce_pkg::CFG_W-1:0] pick_timing();
        logic [31:0] small_val;
        small_val = $urandom_range(1, 8);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return small_val[obcce_pkg::CFG_W-1:0];
        endcase
    endfunction

    // Mostly well-formed clicks, double clicks and holds sized to the current timing.
    task automatic random_gestures(input int quota);
        int start;
        int extra;
        int n;
        start = words_sent;
        extra = (itv == 0) ? 40 : ((itv < 8) ? 3 * itv + 3 : 12);
        while (words_sent - start < quota)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    press_release($urandom_range(1, (thr < 7) ? thr + 1 : 8),
                                  (win < 12) ? win + 2 + $urandom_range(0, 2)
                                             : $urandom_range(1, 12));
                3, 4:
                begin
                    press_release($urandom_range(1, (thr < 7) ? thr + 1 : 8),
                                  $urandom_range(1, (win == 0) ? 1 : ((win < 8) ? win : 8)));
                    press_release($urandom_range(1, (thr < 7) ? thr + 1 : 8),
                                  $urandom_range(1, 3));
                end
                5, 6, 7:
                    press_release((thr < 24) ? thr + 2 + $urandom_range(0, extra)
                                             : $urandom_range(4, 20),
                                  $urandom_range(1, 3));
                default:
                begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_word(1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    initial
    begin : stimulus
        wait (rst_n === 1'b1);
        @(negedge clk);

        // Directed: a single click, a double click back to base, a hold in base, then a repeating hold in up mode.
        program_timing(16'd1, 16'd1, 16'd0);
        press_release(1, 3);
        press_release(1, 1);
        press_release(1, 2);
        press_release(4, 1);
        press_release(5, 3);

        program_timing('0, '0, '0);
        random_gestures(120);
        program_timing('1, '1, '1);
        random_gestures(60);
        program_timing(16'd1, 16'd1, 16'd1);
        random_gestures(120);
        program_timing(obcce_pkg::WINDOW_RESET, obcce_pkg::THRESHOLD_RESET,
                       obcce_pkg::INTERVAL_RESET);
        random_gestures(40);
        while (words_sent < TARGET_WORDS)
        begin
            program_timing(pick_timing(), pick_timing(), pick_timing());
            random_gestures(120);
        end

        drain();
        repeat (8) @(negedge clk);
        $display("Sent %0d button words under %0d timing settings,", words_sent, settings);
        $display("zero and all-ones timings included, with one long result hold-off.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
rtl/obcce_pkg.sv
rtl/obcce_gesture.sv
rtl/obcce_editor.sv
rtl/one_button_click_counter_editor_unit.sv
tb/sv/click_editor_monitor.sv
tb/sv/one_button_click_counter_editor_unit_tb.sv
